// ===== rtl/hed_pkg.sv =====
// ============================================================================
// Hex escape decoder package
// Shared types, character codes and helper functions for the decoder.
// ============================================================================
package hed_pkg;

    // Default width of the decoded length counter.
    localparam int LENGTH_BITS_DEF = 16;
    // Width of the reported length field.
    localparam int LEN_W = 16;
    // Most bytes that one input byte can give.
    localparam int MAX_OUT = 4;
    localparam int IDX_W = $clog2(MAX_OUT);
    // Entries in the queue between the front and the back.
    localparam int Q_DEPTH = 2;

    localparam logic [7:0] CHAR_BSL = 8'h5C;
    localparam logic [7:0] CHAR_X   = 8'h78;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_BACKSLASH = 2'd1,
        MODE_X         = 2'd2,
        MODE_DIGIT     = 2'd3
    } mode_t;

    // One decoded group of bytes, produced by one input byte.
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [IDX_W-1:0]        last_idx;
        logic                    fin;
        logic [LEN_W-1:0]        total;
    } hed_cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
              || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = c - 8'h57;
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        hex_val = v[3:0];
    endfunction

endpackage

// ===== rtl/hex_escape_decoder_core.sv =====
// ============================================================================
// Hex escape decoder core
// Decodes a backslash-escaped byte stream with hex escapes into plain bytes.
// ============================================================================
//
//  Channel  | Direction | Request contents                     | Marker
//  ---------+-----------+--------------------------------------+-----------------
//  s_axis   | in        | tdata[7:0] escaped byte              | tlast ends string
//  m_axis   | out       | tdata[7:0] byte, [23:8] total length | tlast ends string
//
// An input request is taken every cycle while the two-entry command queue has
// room. Each input request gives zero to four output requests; the back end
// issues one output request per cycle from its output register while the
// output is not stalled, so a byte that expands to k bytes gives k requests.
// The first output request of an input request passes through the command
// queue and then the output register before it becomes valid.
// Reset clears the escape state, the length counter, the queue pointers and the
// output valid flag; no clearing pass is needed.
// A stalled output fills the queue, after which s_axis_tready falls.
//
// The front end holds the escape state and works out the whole group of bytes
// for each input request combinationally, along with the saturated length that
// would be reported if the request ends a string. The back end walks through
// that group byte by byte, so the two sides stall independently of each other.
// ============================================================================
module hex_escape_decoder_core #(
    parameter int LENGTH_BITS = hed_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] char_out, [23:8] total_length
    output logic        m_axis_tlast    // final_out
);

    logic              accept;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_head_valid;
    hed_pkg::hed_cmd_t front_cmd;
    hed_pkg::hed_cmd_t head_cmd;
    logic [7:0]                out_char;
    logic [hed_pkg::LEN_W-1:0] out_total;

    // Input requests are held off only by a full queue.
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    hed_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .char_in  (s_axis_tdata),
        .is_final (s_axis_tlast),
        .push     (q_push),
        .cmd      (front_cmd)
    );

    hed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (head_cmd)
    );

    hed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (out_char),
        .out_last   (m_axis_tlast),
        .out_total  (out_total)
    );

    assign m_axis_tdata = {out_total, out_char};

    // Every string end must leave a command in the queue, or its end marker is lost.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |-> q_push)
        else $error("final input request produced no command");

    // The length is only reported on the last byte of a string.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[23:8] == 16'h0000))
        else $error("non-zero length on a byte that does not end a string");

    // The back end may only take from a queue that holds something.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("command taken from an empty queue");

endmodule

// ===== rtl/hed_front.sv =====
// ============================================================================
// Hex escape decoder front end
// Tracks the escape state and turns each accepted byte into a group command.
// ============================================================================
module hed_front #(
    parameter int LENGTH_BITS = hed_pkg::LENGTH_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        char_in,
    input  logic              is_final,
    output logic              push,
    output hed_pkg::hed_cmd_t cmd
);

    localparam int CNT_W = (LENGTH_BITS >= 16) ? 16 : LENGTH_BITS;
    localparam logic [CNT_W+2:0] CAP = {3'b000, {CNT_W{1'b1}}};

    hed_pkg::mode_t mode_reg, mode_next;
    logic [7:0]       held_reg, held_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [hed_pkg::MAX_OUT-1:0][7:0] bytes;
    logic [2:0]                       num;
    logic [CNT_W+2:0]                 sum;
    logic [CNT_W-1:0]                 sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= hed_pkg::MODE_NORMAL;
            held_reg  <= 8'h00;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        bytes     = '0;
        num       = 3'd0;
        case (mode_reg)
            hed_pkg::MODE_NORMAL:
            begin
                if (char_in == hed_pkg::CHAR_BSL)
                begin
                    if (is_final)
                    begin
                        bytes[0] = hed_pkg::CHAR_BSL;
                        num      = 3'd1;
                    end
                    else
                    begin
                        mode_next = hed_pkg::MODE_BACKSLASH;
                    end
                end
                else
                begin
                    bytes[0] = char_in;
                    num      = 3'd1;
                end
            end
            hed_pkg::MODE_BACKSLASH:
            begin
                if (char_in == hed_pkg::CHAR_BSL)
                begin
                    bytes[0]  = hed_pkg::CHAR_BSL;
                    num       = 3'd1;
                    mode_next = hed_pkg::MODE_NORMAL;
                end
                else if (char_in == hed_pkg::CHAR_X)
                begin
                    if (is_final)
                    begin
                        bytes[0] = hed_pkg::CHAR_BSL;
                        bytes[1] = hed_pkg::CHAR_X;
                        num      = 3'd2;
                    end
                    mode_next = hed_pkg::MODE_X;
                end
                else
                begin
                    bytes[0]  = hed_pkg::CHAR_BSL;
                    bytes[1]  = char_in;
                    num       = 3'd2;
                    mode_next = hed_pkg::MODE_NORMAL;
                end
            end
            hed_pkg::MODE_X:
            begin
                if (is_final || !hed_pkg::is_hex(char_in))
                begin
                    bytes[0]  = hed_pkg::CHAR_BSL;
                    bytes[1]  = hed_pkg::CHAR_X;
                    bytes[2]  = char_in;
                    num       = 3'd3;
                    mode_next = hed_pkg::MODE_NORMAL;
                end
                else
                begin
                    held_next = char_in;
                    mode_next = hed_pkg::MODE_DIGIT;
                end
            end
            hed_pkg::MODE_DIGIT:
            begin
                if (hed_pkg::is_hex(char_in))
                begin
                    bytes[0] = {hed_pkg::hex_val(held_reg), hed_pkg::hex_val(char_in)};
                    num      = 3'd1;
                end
                else
                begin
                    bytes[0] = hed_pkg::CHAR_BSL;
                    bytes[1] = hed_pkg::CHAR_X;
                    bytes[2] = held_reg;
                    bytes[3] = char_in;
                    num      = 3'd4;
                end
                mode_next = hed_pkg::MODE_NORMAL;
            end
            default:
            begin
                mode_next = hed_pkg::MODE_NORMAL;
            end
        endcase

        // The count stops at its ceiling, so a sum of several bytes is clipped once.
        sum = {3'b000, count_reg} + {{CNT_W{1'b0}}, num};
        sat = (sum > CAP) ? CAP[CNT_W-1:0] : sum[CNT_W-1:0];

        if (is_final)
        begin
            mode_next = hed_pkg::MODE_NORMAL;
            held_next = 8'h00;
            count_next = '0;
        end
        else
        begin
            count_next = sat;
        end

        if (!accept)
        begin
            mode_next  = mode_reg;
            held_next  = held_reg;
            count_next = count_reg;
        end

        push         = accept && (num != 3'd0);
        cmd.data     = bytes;
        cmd.last_idx = hed_pkg::IDX_W'(num - 3'd1);
        cmd.fin      = is_final;
        cmd.total    = hed_pkg::LEN_W'(sat);
    end

endmodule

// ===== rtl/hed_queue.sv =====
// ============================================================================
// Hex escape decoder command queue
// A short first-in first-out store of group commands between front and back.
// ============================================================================
module hed_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hed_pkg::hed_cmd_t push_cmd,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output hed_pkg::hed_cmd_t head_cmd
);

    localparam int DEPTH = hed_pkg::Q_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hed_pkg::hed_cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_next   = push ? bump(wr_reg) : wr_reg;
        rd_next   = pop ? bump(rd_reg) : rd_reg;
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = mem_reg[rd_reg];

endmodule

// ===== rtl/hed_back.sv =====
// ============================================================================
// Hex escape decoder back end
// Issues queued command bytes one per cycle to the output register unless stalled.
// ============================================================================
module hed_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  hed_pkg::hed_cmd_t         head_cmd,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_char,
    output logic                      out_last,
    output logic [hed_pkg::LEN_W-1:0] out_total
);

    logic [hed_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    logic [7:0]                char_reg, char_next;
    logic                      last_reg, last_next;
    logic [hed_pkg::LEN_W-1:0] total_reg, total_next;
    logic                      load;

    always_comb
    begin
        load       = head_valid && (!valid_reg || out_ready);
        pop        = load && (idx_reg == head_cmd.last_idx);
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        total_next = total_reg;
        if (load)
        begin
            valid_next = 1'b1;
            char_next  = head_cmd.data[idx_reg];
            last_next  = pop && head_cmd.fin;
            total_next = (pop && head_cmd.fin) ? head_cmd.total : '0;
            idx_next   = pop ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        last_reg  <= last_next;
        total_reg <= total_next;
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;
    assign out_total = total_reg;

endmodule
